@@ design/qwsi_pkg.sv @@
// Shared types, constants and the quarter-wave sine table for the sine interpolator.
// No dependencies; every other file of the block imports this package.
`default_nettype none

package qwsi_pkg;

    // Phase word layout: full circle is 2**PHASE_W.
    localparam int PHASE_W   = 14;
    localparam int QUAD_LSB  = 12;
    localparam int QUAD_W    = 2;

    // Quadrant bits: the low bit mirrors the index, the high bit negates.
    localparam int QUAD_MIRROR_BIT = 0;
    localparam int QUAD_NEGATE_BIT = 1;

    // Table: 16 segments over a quarter wave, 17 entries, 15-bit magnitudes.
    localparam int TBL_SEG_BITS = 4;
    localparam int TBL_POS_W    = TBL_SEG_BITS + 1;
    localparam int TBL_LAST     = 16;
    localparam int MAG_W        = 15;
    localparam int SINE_W       = 16;

    // Stream word widths, padded to whole bytes.
    localparam int S_TDATA_W = 16;
    localparam int M_TDATA_W = 16;

    // Default widths of the index and fraction fields.
    localparam int QW_INDEX_BITS    = 4;
    localparam int QW_FRACTION_BITS = 8;

    typedef logic [MAG_W-1:0]     t_mag;
    typedef logic [TBL_POS_W-1:0] t_tbl_pos;
    typedef logic [QUAD_W-1:0]    t_quad;

    // Load strobes for the two registered stages of the interpolation unit.
    typedef struct packed {
        logic mul;
        logic sum;
    } t_interp_ld;

    // Fraction width actually usable below the index field.
    function automatic int frac_width(input int index_bits, input int fraction_bits);
        int room;
        room = QUAD_LSB - index_bits;
        return (fraction_bits > room) ? room : fraction_bits;
    endfunction

    // 32767 * sin(pos * 90 / 16 degrees).
    function automatic t_mag quarter_sine(input t_tbl_pos pos);
        t_mag v;
        case (pos)
            5'd0:    v = 15'd0;
            5'd1:    v = 15'd3211;
            5'd2:    v = 15'd6392;
            5'd3:    v = 15'd9511;
            5'd4:    v = 15'd12539;
            5'd5:    v = 15'd15446;
            5'd6:    v = 15'd18204;
            5'd7:    v = 15'd20787;
            5'd8:    v = 15'd23169;
            5'd9:    v = 15'd25329;
            5'd10:   v = 15'd27244;
            5'd11:   v = 15'd28897;
            5'd12:   v = 15'd30272;
            5'd13:   v = 15'd31356;
            5'd14:   v = 15'd32137;
            5'd15:   v = 15'd32609;
            default: v = 15'd32767;
        endcase
        return v;
    endfunction

endpackage

`default_nettype wire

@@ design/qwsi_decode.sv @@
// First pipeline stage: rounds the phase and splits it into quadrant, index and fraction.
// Depends on qwsi_pkg.
`default_nettype none

module qwsi_decode
    import qwsi_pkg::*;
#(
    parameter int INDEX_BITS    = QW_INDEX_BITS,
    parameter int FRACTION_BITS = QW_FRACTION_BITS
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_load,
    input  wire logic [PHASE_W-1:0]    i_phase,
    output logic      [INDEX_BITS:0]   o_idx_lo,
    output logic      [INDEX_BITS:0]   o_idx_hi,
    output logic      [frac_width(INDEX_BITS, FRACTION_BITS)-1:0] o_frac,
    output t_quad                      o_quad
);

    localparam int IDX_OFF  = QUAD_LSB - INDEX_BITS;
    localparam int FW       = frac_width(INDEX_BITS, FRACTION_BITS);
    localparam int FRAC_OFF = IDX_OFF - FW;

    logic [PHASE_W-1:0]    w_phase;
    logic [INDEX_BITS-1:0] w_idx;
    logic [INDEX_BITS:0]   n_idx_lo;

    // Half an LSB of the fraction is added when bits are dropped below it.
    generate
        if (FRAC_OFF > 0) begin : g_round
            localparam logic [PHASE_W-1:0] HALF = PHASE_W'(1) << (FRAC_OFF - 1);
            assign w_phase = i_phase + HALF;
        end else begin : g_exact
            assign w_phase = i_phase;
        end
    endgenerate

    always_comb begin
        w_idx = w_phase[IDX_OFF +: INDEX_BITS];
        if (w_phase[QUAD_LSB + QUAD_MIRROR_BIT]) begin
            w_idx = ~w_idx;
        end
        n_idx_lo = {1'b0, w_idx};
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            o_idx_lo <= n_idx_lo;
            o_idx_hi <= n_idx_lo + (INDEX_BITS+1)'(1);
            o_frac   <= w_phase[FRAC_OFF +: FW];
            o_quad   <= w_phase[QUAD_LSB +: QUAD_W];
        end
    end

endmodule

`default_nettype wire

@@ design/qwsi_lut.sv @@
// Second pipeline stage: looks up the two table entries that bound the segment.
// Depends on qwsi_pkg.
`default_nettype none

module qwsi_lut
    import qwsi_pkg::*;
#(
    parameter int INDEX_BITS = QW_INDEX_BITS,
    parameter int FW         = QW_FRACTION_BITS
) (
    input  wire logic                i_clk,
    input  wire logic                i_load,
    input  wire logic [INDEX_BITS:0] i_idx_lo,
    input  wire logic [INDEX_BITS:0] i_idx_hi,
    input  wire logic [FW-1:0]       i_frac,
    input  wire t_quad               i_quad,
    output t_mag                     o_x1,
    output t_mag                     o_x2,
    output logic      [FW-1:0]       o_frac,
    output t_quad                    o_quad
);

    localparam int SH_W = INDEX_BITS + 1 + TBL_SEG_BITS;

    // Scale an index onto the 16-segment table; a wider index repeats entries.
    function automatic t_tbl_pos to_pos(input logic [INDEX_BITS:0] idx);
        logic [SH_W-1:0] s;
        s = {idx, {TBL_SEG_BITS{1'b0}}} >> INDEX_BITS;
        return (s > SH_W'(TBL_LAST)) ? TBL_POS_W'(TBL_LAST) : s[TBL_POS_W-1:0];
    endfunction

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            o_x1   <= quarter_sine(to_pos(i_idx_lo));
            o_x2   <= quarter_sine(to_pos(i_idx_hi));
            o_frac <= i_frac;
            o_quad <= i_quad;
        end
    end

endmodule

`default_nettype wire

@@ design/qwsi_interp.sv @@
// Third and fourth pipeline stages: scales the segment slope by the fraction,
// then adds or subtracts it from the segment end and applies the sign. Depends on qwsi_pkg.
`default_nettype none

module qwsi_interp
    import qwsi_pkg::*;
#(
    parameter int FW = QW_FRACTION_BITS
) (
    input  wire logic              i_clk,
    input  wire t_interp_ld        i_ld,
    input  wire t_mag              i_x1,
    input  wire t_mag              i_x2,
    input  wire logic [FW-1:0]     i_frac,
    input  wire t_quad             i_quad,
    output logic      [SINE_W-1:0] o_sine
);

    t_mag                r_base;
    logic [MAG_W+FW-1:0] r_prod;
    t_quad               r_quad;

    t_mag                w_diff;
    t_mag                w_approx;
    t_mag                w_mag;
    logic [SINE_W-1:0]   n_sine;

    // The table rises monotonically, so the slope is never negative.
    assign w_diff = i_x2 - i_x1;

    always_ff @(posedge i_clk) begin
        if (i_ld.mul) begin
            r_prod <= w_diff * i_frac;
            r_base <= i_quad[QUAD_MIRROR_BIT] ? i_x2 : i_x1;
            r_quad <= i_quad;
        end
    end

    always_comb begin
        w_approx = r_prod[FW +: MAG_W];
        w_mag    = r_quad[QUAD_MIRROR_BIT] ? (r_base - w_approx) : (r_base + w_approx);
        n_sine   = r_quad[QUAD_NEGATE_BIT] ? (SINE_W'(0) - {1'b0, w_mag}) : {1'b0, w_mag};
    end

    always_ff @(posedge i_clk) begin
        if (i_ld.sum) begin
            o_sine <= n_sine;
        end
    end

endmodule

`default_nettype wire

@@ design/quarter_wave_sine_interp.sv @@
// Top level of the quarter-wave sine interpolator: stream ports, stage valids and flow control.
// Depends on qwsi_pkg, qwsi_decode, qwsi_lut and qwsi_interp.
`default_nettype none

// Phase-to-sine converter for oscillator and synthesizer data paths. Each input word carries
// a 14-bit phase (full circle = 16384); the top two bits select the quadrant, the next
// INDEX_BITS bits index a 17-entry quarter-wave table and the bits below that interpolate
// linearly between two neighboring entries. Each output word carries the signed 16-bit sine
// scaled by 32767, always within -32767 to 32767. The block is a four-stage pipeline: phase
// decode and index mirroring, table lookup, slope multiplication, and final add with sign.
// It accepts one word per clock unless every stage is full and the output stalls, and returns
// one word per accepted word, in order. An accepted word passes through the decode, lookup,
// multiply and output registers in that order before it shows on the output. Every stage
// holds its own valid bit, so bubbles are squeezed out when the output stalls, and the
// input stays ready as long as any stage is empty.

module quarter_wave_sine_interp
    import qwsi_pkg::*;
#(
    parameter int INDEX_BITS    = QW_INDEX_BITS,
    parameter int FRACTION_BITS = QW_FRACTION_BITS
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    // Input word: tdata[13:0] phase_angle, tdata[15:14] zero.
    input  wire logic                 i_s_tvalid,
    output logic                      o_s_tready,
    input  wire logic [S_TDATA_W-1:0] i_s_tdata,
    // Output word: tdata[15:0] sine_value.
    output logic                      o_m_tvalid,
    input  wire logic                 i_m_tready,
    output logic      [M_TDATA_W-1:0] o_m_tdata
);

    localparam int FW      = frac_width(INDEX_BITS, FRACTION_BITS);
    localparam int NSTAGES = 4;

    // One valid bit per pipeline stage; the last one is the output register.
    logic [NSTAGES-1:0] r_vld;
    logic [NSTAGES-1:0] n_vld;
    logic [NSTAGES-1:0] w_adv;

    logic [INDEX_BITS:0] w_idx_lo;
    logic [INDEX_BITS:0] w_idx_hi;
    logic [FW-1:0]       w_frac1;
    t_quad               w_quad1;
    t_mag                w_x1;
    t_mag                w_x2;
    logic [FW-1:0]       w_frac2;
    t_quad               w_quad2;
    t_interp_ld          w_ld;
    logic [SINE_W-1:0]   w_sine;

    // A stage may take new data when it is empty or when its content moves on.
    always_comb begin
        w_adv[NSTAGES-1] = !r_vld[NSTAGES-1] || i_m_tready;
        for (int k = NSTAGES - 2; k >= 0; k--) begin
            w_adv[k] = !r_vld[k] || w_adv[k+1];
        end
        n_vld[0] = i_s_tvalid;
        for (int k = 1; k < NSTAGES; k++) begin
            n_vld[k] = r_vld[k-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            for (int k = 0; k < NSTAGES; k++) begin
                if (w_adv[k]) begin
                    r_vld[k] <= n_vld[k];
                end
            end
        end
    end

    assign o_s_tready = w_adv[0];
    assign o_m_tvalid = r_vld[NSTAGES-1];
    assign o_m_tdata  = w_sine;

    // Payload registers load only together with a valid word from upstream.
    assign w_ld.mul = w_adv[2] && r_vld[1];
    assign w_ld.sum = w_adv[3] && r_vld[2];

    qwsi_decode #(
        .INDEX_BITS    (INDEX_BITS),
        .FRACTION_BITS (FRACTION_BITS)
    ) u_decode (
        .i_clk    (i_clk),
        .i_load   (w_adv[0] && i_s_tvalid),
        .i_phase  (i_s_tdata[PHASE_W-1:0]),
        .o_idx_lo (w_idx_lo),
        .o_idx_hi (w_idx_hi),
        .o_frac   (w_frac1),
        .o_quad   (w_quad1)
    );

    qwsi_lut #(
        .INDEX_BITS (INDEX_BITS),
        .FW         (FW)
    ) u_lut (
        .i_clk    (i_clk),
        .i_load   (w_adv[1] && r_vld[0]),
        .i_idx_lo (w_idx_lo),
        .i_idx_hi (w_idx_hi),
        .i_frac   (w_frac1),
        .i_quad   (w_quad1),
        .o_x1     (w_x1),
        .o_x2     (w_x2),
        .o_frac   (w_frac2),
        .o_quad   (w_quad2)
    );

    qwsi_interp #(
        .FW (FW)
    ) u_interp (
        .i_clk  (i_clk),
        .i_ld   (w_ld),
        .i_x1   (w_x1),
        .i_x2   (w_x2),
        .i_frac (w_frac2),
        .i_quad (w_quad2),
        .o_sine (w_sine)
    );

    // The output magnitude never exceeds 32767, so the most negative code never shows.
    a_no_min_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> (o_m_tdata != 16'h8000))
        else $error("sine output holds the most negative code");

    // With every stage full and the output stalled, no new word may be taken.
    a_full_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (&r_vld && !i_m_tready) |-> !o_s_tready)
        else $error("input accepted while the pipeline is full and stalled");

    // An accepted word occupies the first stage on the next cycle.
    a_accept_fills: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_tvalid && o_s_tready) |=> r_vld[0])
        else $error("accepted word did not enter the first stage");

    // A held word in the middle of the pipeline is not dropped.
    a_hold_keeps: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_vld[2] && !w_adv[2]) |=> r_vld[2])
        else $error("stalled word lost in the multiply stage");

endmodule

`default_nettype wire
